[sv/frg_pkg.sv]
// Package for the frame range gate: sizes, request and status codes, and the
// structs that pass between the controller, the range table and its cells.
// No dependencies; every other file of the block depends on it.
package frg_pkg;

   // Table and word sizes.
   localparam int MAX_RANGES = 16;
   localparam int FRAME_BITS = 32;
   localparam int RANGE_BITS = 32;
   localparam int CELLS      = MAX_RANGES + 1;
   localparam int IDX_BITS   = $clog2(CELLS);
   localparam int CNT_BITS   = $clog2(CELLS + 1);
   localparam int CMP_BITS   = (FRAME_BITS > RANGE_BITS) ? FRAME_BITS : RANGE_BITS;

   // Request codes carried in req_type.
   typedef enum logic [1:0] {
      REQ_ADD   = 2'd0,
      REQ_FRAME = 2'd1,
      REQ_CLEAR = 2'd2
   } req_code_type;

   // Status codes returned with each result beat.
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   // Operations broadcast to every cell of the table.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PLACE,
      CELL_ABSORB
   } cell_op_type;

   typedef struct packed {
      logic [RANGE_BITS-1:0] lo;
      logic [RANGE_BITS-1:0] hi;
   } range_type;

   // Command shared by all cells.
   typedef struct packed {
      cell_op_type           op;
      range_type             new_range;
      logic [CNT_BITS-1:0]   count;
      logic [FRAME_BITS-1:0] frame;
   } cell_cmd_type;

   // Flags that one cell reports to its neighbors and to the table.
   typedef struct packed {
      logic left;        // valid entry that starts at or below the new low
      logic ext;         // last such entry, and it touches the new range
      logic touch;       // valid entry that overlaps or touches the new range
      logic touch_next;  // this entry touches the valid entry to its right
      logic focus;       // entry that collects the merge
      logic hit;         // registered: entry held the frame number last cycle
   } cell_flags_type;

   // Summary of the whole table for the controller.
   typedef struct packed {
      logic any_touch;
      logic merge_left;
      logic focus_touch;
      logic any_hit;
   } table_status_type;

endpackage

[sv/frg_if.sv]
// Handshake channels of the frame range gate: request beats and result beats.
// Depends on frg_pkg for the field widths.
interface frg_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    req_type;
   logic [frg_pkg::RANGE_BITS-1:0] range_low;
   logic [frg_pkg::RANGE_BITS-1:0] range_high;

   modport source (output valid, req_type, range_low, range_high, input ready);
   modport sink   (input valid, req_type, range_low, range_high, output ready);
endinterface

interface frg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic                          keep;
   logic [frg_pkg::RANGE_BITS-1:0] frame_number;

   modport source (output valid, status, keep, frame_number, input ready);
   modport sink   (input valid, status, keep, frame_number, output ready);
endinterface

[sv/frg_cell.sv]
// One cell of the range table: holds one range, takes data from a neighbor
// when entries move, and judges the frame number. Depends on frg_pkg.
module frg_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [frg_pkg::IDX_BITS-1:0] cell_index,
   input  frg_pkg::cell_cmd_type        cmd,
   input  logic                         merge_left,
   input  frg_pkg::range_type           left_range,
   input  frg_pkg::range_type           right_range,
   input  logic                         left_prev,
   input  logic                         left_next,
   output frg_pkg::range_type           cell_range,
   output frg_pkg::cell_flags_type      flags
);
   import frg_pkg::*;

   range_type           range_ff, range_in;
   logic                focus_ff, focus_in;
   logic                after_ff, after_in;
   logic                hit_ff, hit_in;
   logic                valid;
   logic                next_valid;
   logic                left;
   logic [RANGE_BITS:0] hi_plus;
   logic [RANGE_BITS:0] new_hi_plus;
   logic [CMP_BITS-1:0] frame_wide;

   // Local decisions against the new range and the frame number.
   always_comb begin
      valid       = CNT_BITS'(cell_index) < cmd.count;
      next_valid  = (CNT_BITS'(cell_index) + CNT_BITS'(1)) < cmd.count;
      hi_plus     = {1'b0, range_ff.hi} + (RANGE_BITS + 1)'(1);
      new_hi_plus = {1'b0, cmd.new_range.hi} + (RANGE_BITS + 1)'(1);
      frame_wide  = CMP_BITS'(cmd.frame);
      left        = valid && (range_ff.lo <= cmd.new_range.lo);
      hit_in      = valid && (CMP_BITS'(range_ff.lo) <= frame_wide) &&
                    ((frame_wide <= CMP_BITS'(range_ff.hi)) || (range_ff.hi == '1));
   end

   assign flags.left       = left;
   assign flags.ext        = left && !left_next &&
                             ({1'b0, cmd.new_range.lo} <= hi_plus);
   assign flags.touch      = valid && ({1'b0, range_ff.lo} <= new_hi_plus) &&
                             ({1'b0, cmd.new_range.lo} <= hi_plus);
   assign flags.touch_next = next_valid && ({1'b0, right_range.lo} <= hi_plus);
   assign flags.focus      = focus_ff;
   assign flags.hit        = hit_ff;
   assign cell_range       = range_ff;

   // Entry update for the broadcast operation.
   always_comb begin
      range_in = range_ff;
      focus_in = focus_ff;
      after_in = after_ff;
      case (cmd.op)
         CELL_PLACE: begin
            focus_in = 1'b0;
            after_in = 1'b0;
            if (merge_left) begin
               // The new range joins the last entry that starts at or below it.
               if (flags.ext) begin
                  focus_in = 1'b1;
                  if (cmd.new_range.hi > range_ff.hi) begin
                     range_in.hi = cmd.new_range.hi;
                  end
               end else if (!left) begin
                  after_in = 1'b1;
               end
            end else if (!left) begin
               // Insert: the first cell past the left entries takes the new
               // range, the rest move one place right.
               if (left_prev) begin
                  range_in = cmd.new_range;
                  focus_in = 1'b1;
               end else begin
                  range_in = left_range;
                  after_in = 1'b1;
               end
            end
         end
         CELL_ABSORB: begin
            // The focus entry swallows its right neighbor; later ones close up.
            if (focus_ff) begin
               if (right_range.hi > range_ff.hi) begin
                  range_in.hi = right_range.hi;
               end
            end else if (after_ff) begin
               range_in = right_range;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      range_ff <= range_in;
      if (reset) begin
         focus_ff <= 1'b0;
         after_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         focus_ff <= focus_in;
         after_ff <= after_in;
         hit_ff   <= hit_in;
      end
   end

endmodule

[sv/frg_table.sv]
// Range table of the frame range gate: a row of frg_cell instances wired to
// their neighbors, plus the flag reductions for the controller. Depends on frg_pkg.
module frg_table (
   input  logic                      clock,
   input  logic                      reset,
   input  frg_pkg::cell_cmd_type     cmd,
   output frg_pkg::table_status_type table_status
);
   import frg_pkg::*;

   range_type      ranges [CELLS];
   cell_flags_type flags  [CELLS];
   logic           merge_left;
   logic           any_touch;
   logic           focus_touch;
   logic           any_hit;

   // Row of cells, each linked to the entries on both sides.
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      range_type left_range;
      range_type right_range;
      logic      left_prev;
      logic      left_next;

      if (i == 0) begin : g_first
         assign left_range = ranges[i];
         assign left_prev  = 1'b1;
      end else begin : g_inner_left
         assign left_range = ranges[i-1];
         assign left_prev  = flags[i-1].left;
      end

      if (i == CELLS - 1) begin : g_last
         assign right_range = ranges[i];
         assign left_next   = 1'b0;
      end else begin : g_inner_right
         assign right_range = ranges[i+1];
         assign left_next   = flags[i+1].left;
      end

      frg_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_index  (IDX_BITS'(i)),
         .cmd         (cmd),
         .merge_left  (merge_left),
         .left_range  (left_range),
         .right_range (right_range),
         .left_prev   (left_prev),
         .left_next   (left_next),
         .cell_range  (ranges[i]),
         .flags       (flags[i])
      );
   end

   // Flag reductions across the row.
   always_comb begin
      merge_left  = 1'b0;
      any_touch   = 1'b0;
      focus_touch = 1'b0;
      any_hit     = 1'b0;
      for (int i = 0; i < CELLS; i++) begin
         merge_left  = merge_left | flags[i].ext;
         any_touch   = any_touch | flags[i].touch;
         focus_touch = focus_touch | (flags[i].focus & flags[i].touch_next);
         any_hit     = any_hit | flags[i].hit;
      end
   end

   assign table_status.any_touch   = any_touch;
   assign table_status.merge_left  = merge_left;
   assign table_status.focus_touch = focus_touch;
   assign table_status.any_hit     = any_hit;

endmodule

[sv/frame_range_gate_core.sv]
// Frame range gate: a frame beat passes through ST_FRAME; an add beat passes through
// ST_CHECK, then ST_MERGE, which repeats while the focus entry touches its right neighbor,
// or only ST_CHECK when rejected; clear and unused codes answer from ST_IDLE. Each result
// beat waits in an output register. The absorb loop of the cell row does one merge a step.
// Synchronous active-high reset empties the table, zeros the counter and drop_mode.
// Depends on frg_pkg, frg_if and frg_table.
module frame_range_gate_core (
   input  logic  clock,
   input  logic  reset,
   frg_req_if.sink   req,
   frg_rsp_if.source rsp,
   input  logic  csr_wr_en,
   input  logic  csr_wr_data
);
   import frg_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MERGE,
      ST_FRAME
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic                  drop_ff, drop_in;
   logic [RANGE_BITS-1:0] lo_ff, lo_in;
   logic [RANGE_BITS-1:0] hi_ff, hi_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff, status_in;
   logic                  keep_ff, keep_in;
   logic [RANGE_BITS-1:0] number_ff, number_in;

   logic                  accept;
   logic                  clear_accept;
   cell_op_type           cell_op;
   cell_cmd_type          cmd;
   table_status_type      table_status;

   assign req.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;
   assign clear_accept = accept && (req.req_type == REQ_CLEAR);

   assign cmd.op           = cell_op;
   assign cmd.new_range.lo = lo_ff;
   assign cmd.new_range.hi = hi_ff;
   assign cmd.count        = count_ff;
   assign cmd.frame        = frame_ff;

   frg_table u_table (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .table_status (table_status)
   );

   // Sequencer for requests, table commands and the result register.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      frame_in     = frame_ff;
      drop_in      = csr_wr_en ? csr_wr_data : drop_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      status_in    = status_ff;
      keep_in      = keep_ff;
      number_in    = number_ff;
      cell_op      = CELL_HOLD;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_code_type'(req.req_type))
                  REQ_ADD: begin
                     lo_in    = req.range_low;
                     hi_in    = req.range_high;
                     state_in = ST_CHECK;
                  end
                  REQ_FRAME: begin
                     state_in = ST_FRAME;
                  end
                  REQ_CLEAR: begin
                     count_in     = '0;
                     frame_in     = '0;
                     rsp_valid_in = 1'b1;
                     status_in    = STATUS_OK;
                     keep_in      = 1'b0;
                     number_in    = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     status_in    = STATUS_OK;
                     keep_in      = 1'b0;
                     number_in    = '0;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            // Reject before touching the table, otherwise place the range.
            rsp_valid_in = 1'b1;
            keep_in      = 1'b0;
            number_in    = '0;
            state_in     = ST_IDLE;
            if (lo_ff > hi_ff) begin
               status_in = STATUS_INVALID;
            end else if ((count_ff == CNT_BITS'(MAX_RANGES)) && !table_status.any_touch) begin
               status_in = STATUS_FULL;
            end else begin
               rsp_valid_in = 1'b0;
               cell_op      = CELL_PLACE;
               count_in     = count_ff + CNT_BITS'(!table_status.merge_left);
               state_in     = ST_MERGE;
            end
         end
         ST_MERGE: begin
            // Absorb right neighbors one by one while they touch the focus entry.
            if (table_status.focus_touch) begin
               cell_op  = CELL_ABSORB;
               count_in = count_ff - CNT_BITS'(1);
            end else begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_OK;
               keep_in      = 1'b0;
               number_in    = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_FRAME: begin
            // The cells registered their hits against this counter value.
            rsp_valid_in = 1'b1;
            status_in    = STATUS_OK;
            keep_in      = table_status.any_hit ^ drop_ff;
            number_in    = RANGE_BITS'(frame_ff);
            if (frame_ff != '1) begin
               frame_in = frame_ff + FRAME_BITS'(1);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      status_ff <= status_in;
      keep_ff   <= keep_in;
      number_ff <= number_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         frame_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         frame_ff     <= frame_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.keep         = keep_ff;
   assign rsp.frame_number = number_ff;

   // The table holds at most MAX_RANGES entries outside the merge loop.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_MERGE) |-> (count_ff <= CNT_BITS'(MAX_RANGES)))
      else $error("range count above table size");

   // A waiting result beat blocks new requests.
   a_rsp_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |-> !req.ready)
      else $error("request taken while result beat is stalled");

   // The frame counter only moves forward unless a clear is taken.
   a_frame_monotonic: assert property (@(posedge clock) disable iff (reset)
      !clear_accept |=> (frame_ff >= $past(frame_ff)))
      else $error("frame counter moved backward");

endmodule

[test/frame_range_gate_core_test.sv]
// Self-checking testbench for frame_range_gate_core: range merging, table limits,
// frame keep decisions in both gate modes, under random idling on both channels.
// Depends on frg_pkg, frg_if and the frame_range_gate_core RTL.
`timescale 1ns / 100ps

module frame_range_gate_core_test;
   import frg_pkg::*;

   localparam int          CYCLE_LIMIT = 500000;
   localparam logic [1:0]  REQ_UNUSED  = 2'd3;
   localparam logic [31:0] OPEN_END    = 32'hFFFF_FFFF;

   // One result beat as the gate should produce it.
   typedef struct {
      status_type  status;
      logic        keep;
      logic [31:0] frame_number;
   } gate_result_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   frg_req_if req_ch ();
   frg_rsp_if rsp_ch ();

   frame_range_gate_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the range table, frame counter and gate mode.
   logic [31:0]           shadow_lo [MAX_RANGES];
   logic [31:0]           shadow_hi [MAX_RANGES];
   int unsigned           shadow_count;
   int unsigned           shadow_scan;
   logic [FRAME_BITS-1:0] frame_ctr;
   logic                  drop_sel;

   gate_result_type expected_results [$];
   int              error_count;
   int              idle_pct;
   int              stall_pct;
   int              cycle_count;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Insert a range, merge neighbors that overlap or touch, and report the status.
   function automatic status_type apply_range(input logic [31:0] lo, input logic [31:0] hi);
      logic [31:0] merged_lo [MAX_RANGES+1];
      logic [31:0] merged_hi [MAX_RANGES+1];
      int          n;
      int          m;
      bit          placed;
      n = 0;
      m = 0;
      placed = 0;
      if (lo > hi) return STATUS_INVALID;
      for (int i = 0; i < shadow_count; i++) begin
         if (!placed && lo < shadow_lo[i]) begin
            merged_lo[n] = lo;
            merged_hi[n] = hi;
            n++;
            placed = 1;
         end
         merged_lo[n] = shadow_lo[i];
         merged_hi[n] = shadow_hi[i];
         n++;
      end
      if (!placed) begin
         merged_lo[n] = lo;
         merged_hi[n] = hi;
         n++;
      end
      // An end of all ones touches anything, since every low is at or below it.
      for (int i = 1; i < n; i++) begin
         if (merged_lo[i] <= merged_hi[m] || (merged_lo[i] - merged_hi[m]) == 32'd1) begin
            if (merged_hi[i] > merged_hi[m]) merged_hi[m] = merged_hi[i];
         end else begin
            m++;
            merged_lo[m] = merged_lo[i];
            merged_hi[m] = merged_hi[i];
         end
      end
      m++;
      if (m > MAX_RANGES) return STATUS_FULL;
      for (int i = 0; i < m; i++) begin
         shadow_lo[i] = merged_lo[i];
         shadow_hi[i] = merged_hi[i];
      end
      shadow_count = m;
      shadow_scan = 0;
      return STATUS_OK;
   endfunction

   // Judge the running frame number against the table, then advance the counter.
   function automatic gate_result_type judge_frame();
      gate_result_type res;
      bit              in_range;
      bit              decided;
      in_range = 0;
      decided = 0;
      for (int unsigned i = shadow_scan; i < shadow_count && !decided; i++) begin
         if (shadow_hi[i] != OPEN_END && frame_ctr > shadow_hi[i]) begin
            shadow_scan = i + 1;
         end else begin
            in_range = (frame_ctr >= shadow_lo[i]);
            decided = 1;
         end
      end
      res.status = STATUS_OK;
      res.keep = in_range ^ drop_sel;
      res.frame_number = frame_ctr[31:0];
      if (frame_ctr != '1) frame_ctr = frame_ctr + 1'b1;
      return res;
   endfunction

   // Expected result beat for one accepted request beat.
   function automatic gate_result_type predict_request(input logic [1:0] code,
                                                       input logic [31:0] lo,
                                                       input logic [31:0] hi);
      gate_result_type res;
      res.status = STATUS_OK;
      res.keep = 1'b0;
      res.frame_number = '0;
      case (code)
         REQ_ADD: begin
            res.status = apply_range(lo, hi);
         end
         REQ_FRAME: begin
            res = judge_frame();
         end
         REQ_CLEAR: begin
            shadow_count = 0;
            shadow_scan = 0;
            frame_ctr = '0;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // Send one request beat, with a random idle gap in front of it.
   task automatic send_request(input logic [1:0] code, input logic [31:0] lo,
                               input logic [31:0] hi);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= code;
      req_ch.range_low  <= lo;
      req_ch.range_high <= hi;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_results.push_back(predict_request(code, lo, hi));
   endtask

   // Stop sending and wait until every expected result beat has come back.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the gate mode while the block is idle.
   task automatic set_drop_mode(input logic mode);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      drop_sel = mode;
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_frames(input int count);
      repeat (count) send_request(REQ_FRAME, $urandom, $urandom);
   endtask

   // Merging of touching ranges, an invalid range, the unused code and open end.
   task automatic test_merge_and_gate();
      set_drop_mode(1'b0);
      send_request(REQ_CLEAR, '0, '0);
      send_request(REQ_ADD, 32'd2, 32'd4);
      send_request(REQ_ADD, 32'd6, 32'd7);
      send_request(REQ_ADD, 32'd5, 32'd5);
      send_request(REQ_ADD, 32'd9, 32'd8);
      send_request(REQ_ADD, 32'd0, 32'd0);
      send_request(REQ_UNUSED, OPEN_END, OPEN_END);
      send_frames(9);
      send_request(REQ_ADD, 32'd12, OPEN_END);
      send_frames(4);
   endtask

   // Drop mode inverts the decision; a clear keeps the mode and restarts counting.
   task automatic test_drop_mode();
      set_drop_mode(1'b1);
      send_frames(2);
      send_request(REQ_ADD, OPEN_END, OPEN_END);
      send_request(REQ_ADD, OPEN_END, 32'hFFFF_FFFE);
      send_request(REQ_ADD, 32'd0, OPEN_END);
      send_frames(1);
      send_request(REQ_CLEAR, OPEN_END, OPEN_END);
      send_frames(2);
   endtask

   // Fill the table, overflow it, then merge entries back together.
   task automatic test_table_full();
      set_drop_mode(1'b0);
      send_request(REQ_CLEAR, '0, '0);
      for (int i = MAX_RANGES - 1; i >= 0; i--) begin
         send_request(REQ_ADD, 4 * i, 4 * i + 1);
      end
      send_request(REQ_ADD, 32'd100, 32'd100);
      send_request(REQ_ADD, 32'd2, 32'd2);
      send_frames(8);
      send_request(REQ_ADD, 32'd0, OPEN_END);
      send_frames(2);
   endtask

   // Random traffic: mostly well-formed range and frame sequences near the
   // running frame number, with some clears, table fills and raw noise.
   task automatic test_random_phase(input int n_items, input int idle_p, input int stall_p,
                                    input logic mode);
      int          sent;
      int          pick;
      int          burst;
      int          slot;
      bit          descending;
      logic [31:0] lo;
      logic [31:0] hi;
      set_drop_mode(mode);
      idle_pct = idle_p;
      stall_pct = stall_p;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            send_request($urandom_range(3), $urandom, $urandom);
            sent++;
         end else if (pick < 9) begin
            send_request(REQ_CLEAR, $urandom, $urandom);
            sent++;
         end else if (pick < 11) begin
            // Many disjoint ranges ahead of the counter, to reach the table limit.
            burst = $urandom_range(14, 18);
            descending = $urandom_range(1);
            for (int k = 0; k < burst; k++) begin
               slot = descending ? burst - 1 - k : k;
               lo = frame_ctr[31:0] + 3 * slot + 1;
               send_request(REQ_ADD, lo, lo + (slot % 2));
            end
            sent += burst;
         end else if (pick < 40) begin
            lo = frame_ctr[31:0] + $urandom_range(30);
            lo = lo - ((lo < 10) ? lo : $urandom_range(10));
            case ($urandom_range(19))
               0:       hi = OPEN_END;
               1:       hi = (lo != 0) ? lo - 1 : lo;
               default: hi = lo + $urandom_range(8);
            endcase
            send_request(REQ_ADD, lo, hi);
            sent++;
         end else begin
            burst = $urandom_range(1, 10);
            send_frames(burst);
            sent += burst;
         end
      end
   endtask

   // Result checker and receiver stall generation.
   initial begin : result_checker
      gate_result_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $error("result beat with no request waiting: status %0d keep %0d frame %0d",
                      rsp_ch.status, rsp_ch.keep, rsp_ch.frame_number);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d", want.status,
                         rsp_ch.status);
                  error_count++;
               end
               if (rsp_ch.keep !== want.keep) begin
                  $error("keep mismatch: expected %0d, actual %0d", want.keep, rsp_ch.keep);
                  error_count++;
               end
               if (rsp_ch.frame_number !== want.frame_number) begin
                  $error("frame_number mismatch: expected %0d, actual %0d",
                         want.frame_number, rsp_ch.frame_number);
                  error_count++;
               end
            end
         end
         rsp_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog on the total run length.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("frame_range_gate_core verification failed");
      $finish;
   end

   // Test sequence.
   initial begin
      error_count  = 0;
      idle_pct     = 0;
      stall_pct    = 0;
      shadow_count = 0;
      shadow_scan  = 0;
      frame_ctr    = '0;
      drop_sel     = 1'b0;
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= 1'b0;
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= REQ_CLEAR;
      req_ch.range_low  <= '0;
      req_ch.range_high <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_merge_and_gate();
      test_drop_mode();
      test_table_full();
      test_random_phase(250, 0, 0, 1'b0);
      test_random_phase(250, 63, 0, 1'b1);
      test_random_phase(250, 0, 63, 1'b0);
      test_random_phase(250, 7, 7, 1'b1);

      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("frame_range_gate_core verification clean");
      end else begin
         $display("frame_range_gate_core verification failed");
      end
      $finish;
   end

endmodule
